// ----- rtl/gtp_pkg.sv -----
// Shared types and constants for the genetic-to-physical position converter.
// Holds the channel payload structs, map entry and divider status types.
// No dependencies.
package gtp_pkg;

  localparam int FRAC_BITS = 24;                 // position fraction is value / 2^FRAC_BITS
  localparam int CM_W      = 24;                 // centimorgan Q.8 width
  localparam int BP_W      = 28;                 // base-pair width
  localparam int IDX_W     = 10;                 // load item entry index width
  localparam int CNT_W     = 11;                 // map_entries register width
  localparam int GEN_W     = FRAC_BITS + CM_W;   // genetic target width
  localparam int PROD_W    = BP_W + CM_W;        // scaled interpolation product width
  localparam int DIV_CNT_W = $clog2(BP_W);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_MAP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROM_LEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_ENTRIES = 2'd3;

  localparam logic [CM_W-1:0]  GEN_LENGTH_RST  = 24'd25600;
  localparam logic [BP_W-1:0]  CHROM_LEN_RST   = 28'd100000000;
  localparam logic [CNT_W-1:0] MAP_ENTRIES_RST = 11'd2;

  localparam logic [BP_W-1:0] BP_MAX = {BP_W{1'b1}};

  typedef enum logic [0:0] {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [IDX_W-1:0]     entry_index;
    logic [CM_W-1:0]      entry_cm_q8;
    logic [BP_W-1:0]      entry_bp;
    logic [FRAC_BITS-1:0] position_frac;
    logic                 first_of_run;
  } gtp_in_t;

  typedef struct packed {
    logic [BP_W-1:0] bp_position;
    logic            saturated;
  } gtp_out_t;

  typedef struct packed {
    logic [CM_W-1:0] cm;
    logic [BP_W-1:0] bp;
  } map_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic exact;
  } div_stat_t;

endpackage

// ----- rtl/gtp_map_ram.sv -----
// Map table RAM: one write port, one read port, registered read data.
// Each entry holds a centimorgan and base-pair pair. Uses gtp_pkg.
module gtp_map_ram
  import gtp_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  map_entry_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output map_entry_t    rd_data
);

  map_entry_t mem [DEPTH];
  map_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/gtp_div.sv -----
// Restoring divider, one quotient bit per cycle, BP_W steps.
// The dividend's top CM_W bits must already be below the divisor. Uses gtp_pkg.
module gtp_div
  import gtp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [CM_W-1:0]   divisor,
  output div_stat_t         stat,
  output logic [BP_W-1:0]   quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CM_W-1:0]      rem_r, rem_nxt;
  logic [BP_W-1:0]      quo_r, quo_nxt;
  logic [CM_W-1:0]      dsr_r, dsr_nxt;
  logic [CM_W:0]        trial;
  logic                 ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, quo_r[BP_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(BP_W - 1);
      rem_nxt  = dividend[PROD_W-1 -: CM_W];
      quo_nxt  = dividend[BP_W-1:0];
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? CM_W'(trial - {1'b0, dsr_r}) : trial[CM_W-1:0];
      quo_nxt = {quo_r[BP_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy  = busy_r;
  assign stat.done  = done_r;
  assign stat.exact = (rem_r == '0);
  assign quotient   = quo_r;

endmodule

// ----- rtl/genetic_to_physical_position.sv -----
// Genetic-to-physical position converter. A load item writes one map entry at transfer.
// In direct mode a convert item goes through S_DIRECT, which registers the scaled product,
// and S_FINISH, which loads the output register. In map mode the search walks the map RAM
// one entry per cycle and reads k entries in all (at most the clamped map_entries). An item
// that ends on the first entry, or past the last one, goes from the search to S_FINISH. An
// interpolating item goes on through S_DIFF, S_MUL0, S_MUL1, S_DSTART, the divide in S_DIV
// and S_FINISH; the divide produces one quotient bit per cycle. One item is in work at a
// time. A finished result waits in the output register while the next item is accepted.
// When a result is done while the previous one is still stalled, the converter holds until
// the previous result transfers. Uses gtp_pkg, gtp_map_ram and gtp_div.
module genetic_to_physical_position
  import gtp_pkg::*;
#(
  parameter int MAP_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gtp_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gtp_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = $clog2(MAP_DEPTH);
  localparam int LW = (CNT_W > AW + 1) ? CNT_W : AW + 1;
  localparam int DW = FRAC_BITS + BP_W;
  localparam int PW = BP_W + FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIRECT,
    S_GEN,
    S_SCAN,
    S_DIFF,
    S_MUL0,
    S_MUL1,
    S_DSTART,
    S_DIV,
    S_FINISH
  } state_t;

  // configuration registers
  logic             use_map_r;
  logic [CM_W-1:0]  glen_r;
  logic [BP_W-1:0]  chrom_r;
  logic [CNT_W-1:0] entries_r;

  state_t               state_r, state_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic                 first_r, first_nxt;
  logic [GEN_W-1:0]     g_r, g_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  map_entry_t           lo_r, lo_nxt;
  map_entry_t           hi_r, hi_nxt;
  logic [GEN_W-1:0]     dg_r, dg_nxt;
  logic [CM_W-1:0]      dcm_r, dcm_nxt;
  logic [BP_W-1:0]      mag_r, mag_nxt;
  logic                 desc_r, desc_nxt;
  logic [PW-1:0]        plo_r, plo_nxt;
  logic                 r1z_r, r1z_nxt;
  logic [PROD_W-1:0]    q1_r, q1_nxt;
  logic [BP_W-1:0]      res_r, res_nxt;
  logic [BP_W-1:0]      prev_bp_r, prev_bp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  gtp_out_t             out_data_r, out_data_nxt;

  logic              in_fire, out_fire, fin_go;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  map_entry_t        ram_wdata, ram_rdata;
  logic              hit;
  logic [LW-1:0]     cnt_c;
  logic [DW-1:0]     dir_prod;
  logic [GEN_W-1:0]  gen_prod;
  logic [PROD_W-1:0] phi;
  logic              div_start;
  div_stat_t         div_stat;
  logic [BP_W-1:0]   div_q;
  logic              exact;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign fin_go   = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_map_r <= 1'b0;
      glen_r    <= GEN_LENGTH_RST;
      chrom_r   <= CHROM_LEN_RST;
      entries_r <= MAP_ENTRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_MAP:     use_map_r <= cfg_wdata[0];
        CFG_GEN_LENGTH:  glen_r    <= cfg_wdata[CM_W-1:0];
        CFG_CHROM_LEN:   chrom_r   <= cfg_wdata[BP_W-1:0];
        CFG_MAP_ENTRIES: entries_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // map RAM: loads write at the transfer edge, only the search reads
  assign ram_we    = in_fire && (in_data.cmd == CMD_LOAD) &&
                     (LW'(in_data.entry_index) < LW'(MAP_DEPTH));
  assign ram_waddr = AW'(in_data.entry_index);
  assign ram_wdata = '{cm: in_data.entry_cm_q8, bp: in_data.entry_bp};
  assign ram_re    = (state_r == S_GEN) || (state_r == S_SCAN);
  assign ram_raddr = (state_r == S_GEN) ? '0 : AW'(idx_r + 1'b1);

  gtp_map_ram #(
    .DEPTH(MAP_DEPTH)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign div_start = (state_r == S_DSTART);

  gtp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (q1_r),
    .divisor  (dcm_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign exact = r1z_r && div_stat.exact;

  // clamp the entry count to [2, MAP_DEPTH]
  always_comb begin
    cnt_c = LW'(entries_r);
    if (cnt_c > LW'(MAP_DEPTH)) begin
      cnt_c = LW'(MAP_DEPTH);
    end
    if (cnt_c < LW'(2)) begin
      cnt_c = LW'(2);
    end
  end

  assign hit      = {ram_rdata.cm, {FRAC_BITS{1'b0}}} >= g_r;
  assign dir_prod = DW'(frac_r) * DW'(chrom_r);
  assign gen_prod = GEN_W'(frac_r) * GEN_W'(glen_r);
  assign phi      = PROD_W'(mag_r) * PROD_W'(dg_r[GEN_W-1:FRAC_BITS]);

  always_comb begin
    state_nxt     = state_r;
    frac_nxt      = frac_r;
    first_nxt     = first_r;
    g_nxt         = g_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    dg_nxt        = dg_r;
    dcm_nxt       = dcm_r;
    mag_nxt       = mag_r;
    desc_nxt      = desc_r;
    plo_nxt       = plo_r;
    r1z_nxt       = r1z_r;
    q1_nxt        = q1_r;
    res_nxt       = res_r;
    prev_bp_nxt   = prev_bp_r;
    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.cmd == CMD_CONVERT)) begin
          frac_nxt  = in_data.position_frac;
          first_nxt = in_data.first_of_run;
          state_nxt = use_map_r ? S_GEN : S_DIRECT;
        end
      end
      S_DIRECT: begin
        res_nxt   = dir_prod[FRAC_BITS +: BP_W];
        state_nxt = S_FINISH;
      end
      S_GEN: begin
        g_nxt     = gen_prod;
        last_nxt  = AW'(cnt_c - LW'(1));
        idx_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          if (idx_r == '0) begin
            res_nxt   = ram_rdata.bp;
            state_nxt = S_FINISH;
          end else begin
            hi_nxt    = ram_rdata;
            state_nxt = S_DIFF;
          end
        end else begin
          lo_nxt = ram_rdata;
          if (idx_r == last_r) begin
            res_nxt   = ram_rdata.bp;
            state_nxt = S_FINISH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DIFF: begin
        if (hi_r.cm <= lo_r.cm) begin
          res_nxt   = lo_r.bp;
          state_nxt = S_FINISH;
        end else begin
          dcm_nxt   = hi_r.cm - lo_r.cm;
          dg_nxt    = g_r - {lo_r.cm, {FRAC_BITS{1'b0}}};
          desc_nxt  = hi_r.bp < lo_r.bp;
          mag_nxt   = (hi_r.bp < lo_r.bp) ? lo_r.bp - hi_r.bp : hi_r.bp - lo_r.bp;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        plo_nxt   = PW'(mag_r) * PW'(dg_r[FRAC_BITS-1:0]);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        // drop the FRAC_BITS scale of the genetic offset's fraction before the divide
        q1_nxt    = PROD_W'(plo_r >> FRAC_BITS) + phi;
        r1z_nxt   = (plo_r[FRAC_BITS-1:0] == '0);
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          // descending segments round the step up, so the position rounds down
          if (desc_r) begin
            res_nxt = lo_r.bp - (div_q + BP_W'(!exact));
          end else begin
            res_nxt = lo_r.bp + div_q;
          end
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          out_data_nxt.bp_position = res_r;
          out_data_nxt.saturated   = 1'b0;
          if (!first_r && (res_r == prev_bp_r)) begin
            if (res_r == BP_MAX) begin
              out_data_nxt.saturated = 1'b1;
            end else begin
              out_data_nxt.bp_position = res_r + 1'b1;
            end
          end
          prev_bp_nxt   = out_data_nxt.bp_position;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_bp_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_bp_r   <= prev_bp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    frac_r     <= frac_nxt;
    first_r    <= first_nxt;
    g_r        <= g_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    dg_r       <= dg_nxt;
    dcm_r      <= dcm_nxt;
    mag_r      <= mag_nxt;
    desc_r     <= desc_nxt;
    plo_r      <= plo_nxt;
    r1z_r      <= r1z_nxt;
    q1_r       <= q1_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a repeat within a run is always bumped unless it saturates
  a_repeat_bumped: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && !first_r) |=>
      (out_data_r.bp_position != $past(prev_bp_r) || out_data_r.saturated))
    else $error("repeated position not bumped");

  a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.saturated) |-> (out_data_r.bp_position == BP_MAX))
    else $error("saturated flag without clipped position");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= last_r))
    else $error("map search ran past the last entry");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_stat.done) |-> (div_q <= mag_r))
    else $error("interpolation step exceeds segment height");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == S_IDLE))
    else $error("load transfer started a conversion");

endmodule
